>>> sv/eased_decel_ramp_slew_limited_top_assert.svh
// Assertion macros shared by the checker of the deceleration ramp block.
`ifndef EASED_DECEL_RAMP_SLEW_LIMITED_TOP_ASSERT_SVH
`define EASED_DECEL_RAMP_SLEW_LIMITED_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EDR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("edr: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define EDR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("edr: next-cycle check failed");

`endif

>>> sv/edr_pkg.sv
// Shared types, constants, helper functions and microcode for the deceleration ramp block.
package edr_pkg;

   // Field widths of the channels.
   localparam int RATE_W     = 15;
   localparam int STATUS_W   = 3;
   localparam int TICK_W     = 8;
   localparam int LEN_W      = 11;
   localparam int ELAPSED_W  = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;

   // Rate limits and register reset values.
   localparam logic [RATE_W-1:0] CMD_LIMIT     = 15'd20000;
   localparam logic [RATE_W-1:0] MIN_PPS_RESET = 15'd100;
   localparam logic [RATE_W-1:0] MAX_PPS_RESET = 15'd20000;
   localparam logic [TICK_W-1:0] TICK_MS_RESET = 8'd10;

   // Ramp lengths in milliseconds and the absolute drop threshold.
   localparam logic [LEN_W-1:0]  LEN_SHORT  = 11'd550;
   localparam logic [LEN_W-1:0]  LEN_MID    = 11'd800;
   localparam logic [LEN_W-1:0]  LEN_LONG   = 11'd1000;
   localparam logic [LEN_W-1:0]  LEN_LONGER = 11'd1200;
   localparam logic [RATE_W-1:0] DROP_BIG   = 15'd5000;

   // Slew limit is drop/20, done as (drop >> 2) * ceil(2^18 / 5) >> 18.
   localparam int              RECIP_W     = 16;
   localparam logic [RECIP_W-1:0] SLEW_RECIP = 16'd52429;
   localparam int              SLEW_SHIFT  = 18;

   // Operation codes.
   localparam logic OP_START = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_RAMPING   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DONE      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_MOTOR_OFF = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_BELOW = 3'd3;
   localparam logic [STATUS_W-1:0] ST_IDLE      = 3'd4;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PPS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PPS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_MS = 2'd2;

   // Microcode field widths.
   localparam int ACT_W  = 4;
   localparam int COND_W = 3;
   localparam int UPC_W  = 4;

   // Datapath actions.
   localparam logic [ACT_W-1:0] ACT_NOP    = 4'd0;
   localparam logic [ACT_W-1:0] ACT_WAIT   = 4'd1;
   localparam logic [ACT_W-1:0] ACT_DECODE = 4'd2;
   localparam logic [ACT_W-1:0] ACT_DIV    = 4'd3;
   localparam logic [ACT_W-1:0] ACT_SQUARE = 4'd4;
   localparam logic [ACT_W-1:0] ACT_EASE   = 4'd5;
   localparam logic [ACT_W-1:0] ACT_REDUCE = 4'd6;
   localparam logic [ACT_W-1:0] ACT_SLEW   = 4'd7;
   localparam logic [ACT_W-1:0] ACT_CURVE  = 4'd8;
   localparam logic [ACT_W-1:0] ACT_OUT    = 4'd9;

   // Jump conditions.
   localparam logic [COND_W-1:0] COND_NEVER    = 3'd0;
   localparam logic [COND_W-1:0] COND_NO_REQ   = 3'd1;
   localparam logic [COND_W-1:0] COND_NO_CURVE = 3'd2;
   localparam logic [COND_W-1:0] COND_DIV_MORE = 3'd3;
   localparam logic [COND_W-1:0] COND_OUT_BUSY = 3'd4;

   // Microcode addresses.
   localparam logic [UPC_W-1:0] UA_WAIT   = 4'd0;
   localparam logic [UPC_W-1:0] UA_DECODE = 4'd1;
   localparam logic [UPC_W-1:0] UA_DIV    = 4'd2;
   localparam logic [UPC_W-1:0] UA_SQUARE = 4'd3;
   localparam logic [UPC_W-1:0] UA_EASE   = 4'd4;
   localparam logic [UPC_W-1:0] UA_REDUCE = 4'd5;
   localparam logic [UPC_W-1:0] UA_SLEW   = 4'd6;
   localparam logic [UPC_W-1:0] UA_CURVE  = 4'd7;
   localparam logic [UPC_W-1:0] UA_OUT    = 4'd8;

   // One control word: action, jump condition, jump target, and return to wait on fall-through.
   typedef struct packed {
      logic [ACT_W-1:0]  act;
      logic [COND_W-1:0] cond;
      logic [UPC_W-1:0]  target;
      logic              ret;
   } ucode_type;

   // Control program.
   function automatic ucode_type ucode_rom(input logic [UPC_W-1:0] addr);
      ucode_type w;
      w = '{act: ACT_NOP, cond: COND_NEVER, target: UA_WAIT, ret: 1'b1};
      unique case (addr)
         UA_WAIT:   w = '{act: ACT_WAIT,   cond: COND_NO_REQ,   target: UA_WAIT, ret: 1'b0};
         UA_DECODE: w = '{act: ACT_DECODE, cond: COND_NO_CURVE, target: UA_OUT,  ret: 1'b0};
         UA_DIV:    w = '{act: ACT_DIV,    cond: COND_DIV_MORE, target: UA_DIV,  ret: 1'b0};
         UA_SQUARE: w = '{act: ACT_SQUARE, cond: COND_NEVER,    target: UA_WAIT, ret: 1'b0};
         UA_EASE:   w = '{act: ACT_EASE,   cond: COND_NEVER,    target: UA_WAIT, ret: 1'b0};
         UA_REDUCE: w = '{act: ACT_REDUCE, cond: COND_NEVER,    target: UA_WAIT, ret: 1'b0};
         UA_SLEW:   w = '{act: ACT_SLEW,   cond: COND_NEVER,    target: UA_WAIT, ret: 1'b0};
         UA_CURVE:  w = '{act: ACT_CURVE,  cond: COND_NEVER,    target: UA_WAIT, ret: 1'b0};
         UA_OUT:    w = '{act: ACT_OUT,    cond: COND_OUT_BUSY, target: UA_OUT,  ret: 1'b1};
         default:   w = '{act: ACT_NOP,    cond: COND_NEVER,    target: UA_WAIT, ret: 1'b1};
      endcase
      return w;
   endfunction

   // Clamp a rate to the command limit.
   function automatic logic [RATE_W-1:0] lim(input logic [RATE_W-1:0] v);
      return (v > CMD_LIMIT) ? CMD_LIMIT : v;
   endfunction

   // Clamp to the upper bound, then to the lower bound; the lower bound wins when they cross.
   function automatic logic [RATE_W-1:0] bound(input logic [RATE_W-1:0] v,
                                               input logic [RATE_W-1:0] hi,
                                               input logic [RATE_W-1:0] lo);
      logic [RATE_W-1:0] t;
      t = (v > hi) ? hi : v;
      return (t < lo) ? lo : t;
   endfunction

endpackage

>>> sv/eased_decel_ramp_slew_limited_top.sv
// Deceleration ramp generator run by a microcoded sequencer over a shared multiplier and a divider.
// Sequence: a request is taken in the wait step and decoded; a start item, or a tick that ends
//    or finds no ramp, goes straight to the output step, while a tick on the curve first passes
//    the divide, square, ease, reduce, slew and curve steps. No new item is taken until the output
//    step has loaded its result while no earlier result stalls; the divider gives two quotient bits per cycle.
// Reset: synchronous, active high; clears ramp, sequencer and response; loads register defaults.
module eased_decel_ramp_slew_limited_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_operation,
   input  logic [edr_pkg::RATE_W-1:0]    req_target_speed,
   input  logic [edr_pkg::RATE_W-1:0]    req_current_speed,
   input  logic                          req_motor_on,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [edr_pkg::RATE_W-1:0]    rsp_speed_command,
   output logic                          rsp_command_valid,
   output logic [edr_pkg::STATUS_W-1:0]  rsp_status,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [edr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [edr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import edr_pkg::*;

   // Derived sizes of the fixed-point datapath.
   localparam int DIV_STEPS = (FRAC_BITS + 1) / 2;
   localparam int QBITS     = 2 * DIV_STEPS;
   localparam int CNT_W     = $clog2(DIV_STEPS);
   localparam int MA_W      = (FRAC_BITS > RATE_W) ? FRAC_BITS : RATE_W;
   localparam int MB_W      = (FRAC_BITS + 1 > RECIP_W) ? FRAC_BITS + 1 : RECIP_W;
   localparam int PW        = MA_W + MB_W;
   localparam int CMP_W     = RATE_W + 4;
   localparam logic [CNT_W-1:0]   DIV_LAST = CNT_W'(DIV_STEPS - 1);
   localparam logic [FRAC_BITS:0] ONE      = {1'b1, {FRAC_BITS{1'b0}}};

   // Configuration registers.
   logic [RATE_W-1:0] min_pps_ff, max_pps_ff;
   logic [TICK_W-1:0] tick_ms_ff;

   // Captured input item.
   logic              op_ff, motor_ff;
   logic [RATE_W-1:0] tgt_ff, cur_ff;

   // Ramp state.
   logic                 active_ff, active_in;
   logic [RATE_W-1:0]    start_ff, start_in, drop_ff, drop_in, final_ff, final_in;
   logic [RATE_W-1:0]    prev_ff, prev_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;

   // Working registers of the curve computation.
   logic [ELAPSED_W-1:0] rem_ff, rem_in;
   logic [QBITS-1:0]     quot_ff, quot_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 half_ff, half_in;
   logic [FRAC_BITS:0]   ease_ff, ease_in;
   logic [PW-1:0]        prod_ff, prod_in;
   logic [RATE_W-1:0]    red_ff, red_in;

   // Result of the current item and the response register.
   logic [RATE_W-1:0]   res_cmd_ff, res_cmd_in;
   logic                res_cv_ff, res_cv_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in, rsp_load;
   logic [RATE_W-1:0]   rsp_cmd_ff;
   logic                rsp_cv_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   // Sequencer.
   logic [UPC_W-1:0] upc_ff, upc_in;
   ucode_type        uw;
   logic             jump, curve_go, out_busy;

   // Combinational datapath values.
   logic [RATE_W-1:0]    lo, hi, tgt_l, cur_l, tgt_r, drop_s, bound_cur;
   logic [CMP_W-1:0]     drop10, cur3, cur6;
   logic [LEN_W-1:0]     len_s;
   logic [TICK_W-1:0]    step;
   logic [ELAPSED_W:0]   esum;
   logic [ELAPSED_W-1:0] esat, len12, r1, r1b, r2, r2b;
   logic                 ge1, ge2;
   logic [FRAC_BITS-1:0] p, x_sq;
   logic [PW-1:0]        sq_sh;
   logic [MA_W-1:0]      mul_a;
   logic [MB_W-1:0]      mul_b;
   logic [RATE_W-1:0]    slew, rate0, rate1, rate2;

   assign uw        = ucode_rom(upc_ff);
   assign req_ready = (uw.act == ACT_WAIT);
   assign csr_ready = 1'b1;
   assign out_busy  = rsp_valid_ff && !rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_speed_command = rsp_cmd_ff;
   assign rsp_command_valid = rsp_cv_ff;
   assign rsp_status        = rsp_status_ff;

   // Start decode: clamp inputs, raise the target to the floor, pick the ramp length.
   always_comb begin
      lo        = lim(min_pps_ff);
      hi        = lim(max_pps_ff);
      tgt_l     = lim(tgt_ff);
      cur_l     = lim(cur_ff);
      tgt_r     = (tgt_l < lo) ? lo : tgt_l;
      drop_s    = (tgt_r < cur_l) ? cur_l - tgt_r : '0;
      bound_cur = bound(cur_l, hi, lo);
      drop10    = (CMP_W'(drop_s) << 3) + (CMP_W'(drop_s) << 1);
      cur3      = (CMP_W'(cur_l) << 1) + CMP_W'(cur_l);
      cur6      = cur3 << 1;
      priority if (drop10 < cur3) len_s = LEN_SHORT;
      else if (drop10 < cur6)     len_s = LEN_MID;
      else if (drop_s < DROP_BIG) len_s = LEN_LONG;
      else                        len_s = LEN_LONGER;
   end

   // Tick time advance with saturation, and the test for a tick that stays on the curve.
   always_comb begin
      step     = (tick_ms_ff == '0) ? TICK_W'(1) : tick_ms_ff;
      esum     = (ELAPSED_W + 1)'(elapsed_ff) + (ELAPSED_W + 1)'(step);
      esat     = esum[ELAPSED_W] ? '1 : esum[ELAPSED_W-1:0];
      len12    = ELAPSED_W'(len_ff);
      curve_go = (op_ff == OP_TICK) && active_ff && motor_ff && (esat < len12);
   end

   // Two restoring division steps per cycle for the progress quotient.
   always_comb begin
      r1  = {rem_ff[ELAPSED_W-2:0], 1'b0};
      ge1 = (r1 >= len12);
      r1b = ge1 ? r1 - len12 : r1;
      r2  = {r1b[ELAPSED_W-2:0], 1'b0};
      ge2 = (r2 >= len12);
      r2b = ge2 ? r2 - len12 : r2;
   end

   // Ease curve operands and the shared multiplier inputs.
   always_comb begin
      p     = quot_ff[QBITS-1 -: FRAC_BITS];
      x_sq  = p[FRAC_BITS-1] ? (~p) + FRAC_BITS'(1) : p;
      sq_sh = prod_ff >> (FRAC_BITS - 1);
      mul_a = '0;
      mul_b = '0;
      unique case (uw.act)
         ACT_SQUARE: begin
            mul_a = MA_W'(x_sq);
            mul_b = MB_W'(x_sq);
         end
         ACT_REDUCE: begin
            mul_a = MA_W'(drop_ff);
            mul_b = MB_W'(ease_ff);
         end
         ACT_SLEW: begin
            mul_a = MA_W'(drop_ff >> 2);
            mul_b = MB_W'(SLEW_RECIP);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Curve rate: subtract the reduction, bound it, then limit the fall per tick.
   always_comb begin
      slew  = RATE_W'(prod_ff >> SLEW_SHIFT);
      rate0 = (red_ff >= start_ff) ? '0 : start_ff - red_ff;
      rate1 = bound(rate0, hi, lo);
      rate2 = ((prev_ff > rate1) && ((prev_ff - rate1) > slew)) ? prev_ff - slew : rate1;
   end

   // Next step of the control program.
   always_comb begin
      unique case (uw.cond)
         COND_NEVER:    jump = 1'b0;
         COND_NO_REQ:   jump = !req_valid;
         COND_NO_CURVE: jump = !curve_go;
         COND_DIV_MORE: jump = (cnt_ff != DIV_LAST);
         COND_OUT_BUSY: jump = out_busy;
         default:       jump = 1'b0;
      endcase
      if (jump) begin
         upc_in = uw.target;
      end else if (uw.ret) begin
         upc_in = UA_WAIT;
      end else begin
         upc_in = upc_ff + UPC_W'(1);
      end
   end

   // Datapath actions selected by the control word.
   always_comb begin
      active_in     = active_ff;
      start_in      = start_ff;
      drop_in       = drop_ff;
      final_in      = final_ff;
      prev_in       = prev_ff;
      len_in        = len_ff;
      elapsed_in    = elapsed_ff;
      rem_in        = rem_ff;
      quot_in       = quot_ff;
      cnt_in        = cnt_ff;
      half_in       = half_ff;
      ease_in       = ease_ff;
      prod_in       = prod_ff;
      red_in        = red_ff;
      res_cmd_in    = res_cmd_ff;
      res_cv_in     = res_cv_ff;
      res_status_in = res_status_ff;
      rsp_load      = 1'b0;
      unique case (uw.act)
         ACT_DECODE: begin
            res_cmd_in = '0;
            res_cv_in  = 1'b0;
            if (op_ff == OP_START) begin
               if (!motor_ff) begin
                  res_status_in = ST_MOTOR_OFF;
               end else if (tgt_l >= cur_l) begin
                  res_status_in = ST_NOT_BELOW;
               end else begin
                  active_in     = 1'b1;
                  start_in      = cur_l;
                  drop_in       = drop_s;
                  final_in      = tgt_r;
                  len_in        = len_s;
                  elapsed_in    = '0;
                  prev_in       = bound_cur;
                  res_cmd_in    = bound_cur;
                  res_cv_in     = 1'b1;
                  res_status_in = ST_RAMPING;
               end
            end else if (!active_ff) begin
               res_status_in = ST_IDLE;
            end else begin
               elapsed_in = esat;
               rem_in     = esat;
               quot_in    = '0;
               cnt_in     = '0;
               if (!motor_ff) begin
                  active_in     = 1'b0;
                  res_cmd_in    = lim(final_ff);
                  res_cv_in     = 1'b1;
                  res_status_in = ST_MOTOR_OFF;
               end else if (esat >= len12) begin
                  active_in     = 1'b0;
                  res_cmd_in    = lim(final_ff);
                  res_cv_in     = 1'b1;
                  res_status_in = ST_DONE;
               end
            end
         end
         ACT_DIV: begin
            rem_in  = r2b;
            quot_in = {quot_ff[QBITS-3:0], ge1, ge2};
            cnt_in  = cnt_ff + CNT_W'(1);
         end
         ACT_SQUARE: begin
            half_in = p[FRAC_BITS-1];
            prod_in = PW'(mul_a) * PW'(mul_b);
         end
         ACT_EASE: begin
            ease_in = half_ff ? ONE - (FRAC_BITS + 1)'(sq_sh) : (FRAC_BITS + 1)'(sq_sh);
         end
         ACT_REDUCE: begin
            prod_in = PW'(mul_a) * PW'(mul_b);
         end
         ACT_SLEW: begin
            red_in  = RATE_W'(prod_ff >> FRAC_BITS);
            prod_in = PW'(mul_a) * PW'(mul_b);
         end
         ACT_CURVE: begin
            prev_in       = rate2;
            res_cmd_in    = lim(rate2);
            res_cv_in     = 1'b1;
            res_status_in = ST_RAMPING;
         end
         ACT_OUT: begin
            rsp_load = !out_busy;
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
   end

   // Response valid: set when a result is loaded, cleared by its transfer.
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= UA_WAIT;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         min_pps_ff   <= MIN_PPS_RESET;
         max_pps_ff   <= MAX_PPS_RESET;
         tick_ms_ff   <= TICK_MS_RESET;
      end else begin
         upc_ff       <= upc_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_MIN_PPS: min_pps_ff <= csr_wdata[RATE_W-1:0];
               CSR_MAX_PPS: max_pps_ff <= csr_wdata[RATE_W-1:0];
               CSR_TICK_MS: tick_ms_ff <= csr_wdata[TICK_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers: captured inputs, ramp values and working values.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff    <= req_operation;
         tgt_ff   <= req_target_speed;
         cur_ff   <= req_current_speed;
         motor_ff <= req_motor_on;
      end
      start_ff      <= start_in;
      drop_ff       <= drop_in;
      final_ff      <= final_in;
      prev_ff       <= prev_in;
      len_ff        <= len_in;
      elapsed_ff    <= elapsed_in;
      rem_ff        <= rem_in;
      quot_ff       <= quot_in;
      cnt_ff        <= cnt_in;
      half_ff       <= half_in;
      ease_ff       <= ease_in;
      prod_ff       <= prod_in;
      red_ff        <= red_in;
      res_cmd_ff    <= res_cmd_in;
      res_cv_ff     <= res_cv_in;
      res_status_ff <= res_status_in;
      if (rsp_load) begin
         rsp_cmd_ff    <= res_cmd_ff;
         rsp_cv_ff     <= res_cv_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

endmodule

>>> sv/edr_checker.sv
// Port-level checker for the deceleration ramp block and its bind to the top level.
`include "eased_decel_ramp_slew_limited_top_assert.svh"

module edr_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [edr_pkg::RATE_W-1:0]   rsp_speed_command,
   input logic                         rsp_command_valid,
   input logic [edr_pkg::STATUS_W-1:0] rsp_status
);
   import edr_pkg::*;

   localparam int PAYLOAD_W = RATE_W + 1 + STATUS_W;

   // Response conditions that the checks below look at.
   logic                 rsp_no_cmd, rsp_cmd, rsp_reject, rsp_stall, cmd_ok;
   logic [PAYLOAD_W-1:0] rsp_payload;

   assign rsp_no_cmd  = rsp_valid && !rsp_command_valid;
   assign rsp_cmd     = rsp_valid && rsp_command_valid;
   assign rsp_reject  = rsp_valid && (rsp_status == ST_NOT_BELOW || rsp_status == ST_IDLE);
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign cmd_ok      = (rsp_speed_command <= CMD_LIMIT) &&
                        (rsp_status == ST_RAMPING || rsp_status == ST_DONE ||
                         rsp_status == ST_MOTOR_OFF);
   assign rsp_payload = {rsp_speed_command, rsp_command_valid, rsp_status};

   // A result without a command carries a zero rate.
   `EDR_ASSERT_NOW(a_no_cmd_zero, clock, reset, rsp_no_cmd, rsp_speed_command == '0)

   // A command stays within the limit and comes only with ramping, done or motor-off status.
   `EDR_ASSERT_NOW(a_cmd_status, clock, reset, rsp_cmd, cmd_ok)

   // Rejected starts and idle ticks never carry a command.
   `EDR_ASSERT_NOW(a_reject_no_cmd, clock, reset, rsp_reject, !rsp_command_valid)

   // A stalled result holds until its transfer.
   `EDR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload))

endmodule

bind eased_decel_ramp_slew_limited_top edr_checker u_edr_checker (.*);

>>> test/eased_decel_ramp_slew_limited_top_tb.sv
// Self-checking testbench for the eased deceleration ramp block with its own ramp predictor.
`timescale 1ns / 100ps

module eased_decel_ramp_slew_limited_top_tb;
   import edr_pkg::*;

   localparam int FRAC_BITS   = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE      = 24;

   // One request and one response as they cross the ports.
   typedef struct packed {
      logic              op;
      logic [RATE_W-1:0] target;
      logic [RATE_W-1:0] current;
      logic              motor_on;
   } ramp_req_type;

   typedef struct packed {
      logic [RATE_W-1:0]   speed;
      logic                valid;
      logic [STATUS_W-1:0] status;
   } ramp_cmd_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_operation = 1'b0;
   logic [RATE_W-1:0]     req_target_speed = '0;
   logic [RATE_W-1:0]     req_current_speed = '0;
   logic                  req_motor_on = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [RATE_W-1:0]     rsp_speed_command;
   logic                  rsp_command_valid;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Request backlog, expected commands and run bookkeeping.
   ramp_req_type queued_requests[$];
   ramp_cmd_type expected_commands[$];
   ramp_req_type bus_request;
   int           mismatch_count = 0;
   int           cycle_count = 0;
   int           send_gap = 0;
   int           accept_gap = 0;
   bit           quiet = 1'b0;

   // Shadow copy of the configuration registers.
   logic [RATE_W-1:0] min_pps_r = 15'd100;
   logic [RATE_W-1:0] max_pps_r = 15'd20000;
   logic [TICK_W-1:0] tick_ms_r = 8'd10;

   // Shadow copy of the ramp state.
   logic              ramp_running = 1'b0;
   logic [RATE_W-1:0] ramp_start_rate = '0;
   logic [RATE_W-1:0] ramp_drop = '0;
   logic [RATE_W-1:0] ramp_final = '0;
   logic [LEN_W-1:0]  ramp_len_ms = '0;
   logic [11:0]       ramp_elapsed_ms = '0;
   logic [RATE_W-1:0] last_rate = '0;

   eased_decel_ramp_slew_limited_top #(.FRAC_BITS(FRAC_BITS)) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_target_speed  (req_target_speed),
      .req_current_speed (req_current_speed),
      .req_motor_on      (req_motor_on),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_speed_command (rsp_speed_command),
      .rsp_command_valid (rsp_command_valid),
      .rsp_status        (rsp_status),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Every command is held to the 20000 pulse-per-second ceiling.
   function automatic logic [RATE_W-1:0] cap_cmd(input int unsigned v);
      logic [RATE_W-1:0] r;
      r = (v > 20000) ? 15'd20000 : v[RATE_W-1:0];
      return r;
   endfunction

   // Upper limit first, then the lower one, so a crossed pair lets min_pps win.
   function automatic int unsigned fence_rate(input int unsigned v);
      int unsigned hi, lo;
      hi = cap_cmd(max_pps_r);
      lo = cap_cmd(min_pps_r);
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v;
   endfunction

   // Works out the command for one accepted request and advances the shadow ramp.
   function automatic ramp_cmd_type next_ramp_command(input ramp_req_type rq);
      ramp_cmd_type      res;
      int unsigned       tgt, cur, lo, drop, stride, elapsed, rate, slew;
      longint unsigned   prog, eased, rem, red;
      longint unsigned   one;
      one = longint'(1) << FRAC_BITS;
      res = '{speed: '0, valid: 1'b0, status: ST_IDLE};
      if (rq.op == OP_START) begin
         tgt = cap_cmd(rq.target);
         cur = cap_cmd(rq.current);
         lo  = cap_cmd(min_pps_r);
         if (!rq.motor_on) begin
            res.status = ST_MOTOR_OFF;
         end else if (tgt >= cur) begin
            res.status = ST_NOT_BELOW;
         end else begin
            // Raising the target to min_pps may leave nothing to drop.
            if (tgt < lo) tgt = lo;
            drop = (tgt < cur) ? cur - tgt : 0;
            if (10 * drop < 3 * cur) ramp_len_ms = 11'd550;
            else if (10 * drop < 6 * cur) ramp_len_ms = 11'd800;
            else if (drop < 5000) ramp_len_ms = 11'd1000;
            else ramp_len_ms = 11'd1200;
            ramp_running    = 1'b1;
            ramp_start_rate = RATE_W'(cur);
            ramp_drop       = RATE_W'(drop);
            ramp_final      = RATE_W'(tgt);
            ramp_elapsed_ms = '0;
            last_rate       = cap_cmd(fence_rate(cur));
            res = '{speed: last_rate, valid: 1'b1, status: ST_RAMPING};
         end
      end else if (ramp_running) begin
         stride  = (tick_ms_r == 0) ? 1 : tick_ms_r;
         elapsed = ramp_elapsed_ms + stride;
         if (elapsed > 4095) elapsed = 4095;
         ramp_elapsed_ms = 12'(elapsed);
         if (!rq.motor_on || elapsed >= ramp_len_ms) begin
            ramp_running = 1'b0;
            res = '{speed: cap_cmd(ramp_final), valid: 1'b1,
                    status: rq.motor_on ? ST_DONE : ST_MOTOR_OFF};
         end else begin
            // Quadratic ease-in-out on a Q16 progress value, all shifts truncating.
            prog = elapsed;
            prog = (prog << FRAC_BITS) / ramp_len_ms;
            if (prog < (one >> 1)) begin
               eased = (prog * prog) >> (FRAC_BITS - 1);
            end else begin
               rem   = one - prog;
               eased = one - ((rem * rem) >> (FRAC_BITS - 1));
            end
            red  = (longint'(ramp_drop) * eased) >> FRAC_BITS;
            rate = (red >= ramp_start_rate) ? 0 : ramp_start_rate - int'(red);
            rate = fence_rate(rate);
            // The fall from the previous command is limited to a twentieth of the drop.
            slew = ramp_drop / 20;
            if (last_rate > rate && last_rate - rate > slew) rate = last_rate - slew;
            last_rate = cap_cmd(rate);
            res = '{speed: last_rate, valid: 1'b1, status: ST_RAMPING};
         end
      end
      return res;
   endfunction

   task automatic compare_field(input string field, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      end
   endtask

   task automatic push_request(input logic op, input int unsigned tgt, input int unsigned cur,
                               input logic motor);
      ramp_req_type rq;
      rq = '{op: op, target: tgt[RATE_W-1:0], current: cur[RATE_W-1:0], motor_on: motor};
      queued_requests.push_back(rq);
   endtask

   // Mostly complete ramps with random content; the rest is stray traffic.
   task automatic gen_traffic(input int n);
      int made, ticks, cur, top, tgt;
      made = 0;
      while (made < n) begin
         if ($urandom_range(0, 99) < 80) begin
            cur = ($urandom_range(0, 9) == 0) ? $urandom_range(20001, 32767)
                                              : $urandom_range(1, 20000);
            top = (cur > 20000) ? 20000 : cur;
            if ($urandom_range(0, 5) == 0)
               tgt = $urandom_range(0, (top < 200) ? top - 1 : 199);
            else
               tgt = $urandom_range(0, top - 1);
            push_request(OP_START, tgt, cur, 1'b1);
            made++;
            ticks = $urandom_range(1, 130);
            for (int i = 0; i < ticks && made < n; i++) begin
               if ($urandom_range(0, 39) == 0) begin
                  push_request(OP_START, $urandom_range(0, 32767), $urandom_range(0, 32767),
                               1'($urandom_range(0, 1)));
                  made++;
               end else if ($urandom_range(0, 59) == 0) begin
                  push_request(OP_TICK, $urandom_range(0, 32767), $urandom_range(0, 32767),
                               1'b0);
                  made++;
                  break;
               end else begin
                  push_request(OP_TICK, $urandom_range(0, 32767), $urandom_range(0, 32767),
                               1'b1);
                  made++;
               end
            end
         end else begin
            push_request(1'($urandom_range(0, 1)), $urandom_range(0, 32767),
                         $urandom_range(0, 32767), 1'($urandom_range(0, 1)));
            made++;
         end
      end
   endtask

   // Waits until nothing is queued, on the bus or outstanding, then lets the block settle.
   task automatic wait_drain();
      @(negedge clock);
      while (queued_requests.size() != 0 || expected_commands.size() != 0 || req_valid)
         @(negedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      unique case (idx)
         CSR_MIN_PPS: min_pps_r = data[RATE_W-1:0];
         CSR_MAX_PPS: max_pps_r = data[RATE_W-1:0];
         CSR_TICK_MS: tick_ms_r = data[TICK_W-1:0];
         default: ;
      endcase
   endtask

   // Each phase starts from an idle block with a fresh register setting.
   task automatic run_phase(input int unsigned lo, input int unsigned hi, input int unsigned tk,
                            input int n, input bit calm);
      wait_drain();
      quiet = calm;
      write_reg(CSR_MIN_PPS, lo);
      write_reg(CSR_MAX_PPS, hi);
      write_reg(CSR_TICK_MS, tk);
      @(negedge clock);
      gen_traffic(n);
   endtask

   // Request driver: predicts on each transfer and presents the next request.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready)
            expected_commands.push_back(next_ramp_command(bus_request));
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 11) == 0) begin
               send_gap = $urandom_range(0, 10);
               req_valid <= 1'b0;
            end else if (queued_requests.size() != 0) begin
               bus_request = queued_requests.pop_front();
               req_valid         <= 1'b1;
               req_operation     <= bus_request.op;
               req_target_speed  <= bus_request.target;
               req_current_speed <= bus_request.current;
               req_motor_on      <= bus_request.motor_on;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks each transfer against the oldest expected command.
   always @(posedge clock) begin
      ramp_cmd_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         accept_gap = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_commands.size() == 0) begin
               mismatch_count++;
               $display("%0t: response expected none actual %0d/%0d/%0d", $time,
                        rsp_speed_command, rsp_command_valid, rsp_status);
            end else begin
               want = expected_commands.pop_front();
               compare_field("speed_command", want.speed, rsp_speed_command);
               compare_field("command_valid", want.valid, rsp_command_valid);
               compare_field("status", want.status, rsp_status);
            end
         end
         if (accept_gap > 0) begin
            accept_gap--;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 11) == 0) begin
            accept_gap = $urandom_range(0, 10);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("eased_decel_ramp_slew_limited_top: mismatch");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed requests under the reset register values.
      push_request(OP_TICK, 0, 0, 1'b1);
      push_request(OP_START, 100, 5000, 1'b0);
      push_request(OP_START, 3000, 3000, 1'b1);
      push_request(OP_START, 32767, 0, 1'b1);
      push_request(OP_START, 0, 32767, 1'b1);
      repeat (3) push_request(OP_TICK, 32767, 32767, 1'b1);
      push_request(OP_START, 500, 8000, 1'b0);
      push_request(OP_TICK, 0, 0, 1'b1);
      push_request(OP_START, 9000, 9000, 1'b1);
      push_request(OP_TICK, 0, 0, 1'b0);
      push_request(OP_TICK, 0, 0, 1'b1);
      push_request(OP_START, 9000, 10000, 1'b1);
      push_request(OP_START, 6000, 10000, 1'b1);
      repeat (2) push_request(OP_TICK, 0, 0, 1'b1);
      push_request(OP_START, 50, 1000, 1'b1);
      push_request(OP_TICK, 0, 0, 1'b1);
      push_request(OP_START, 10, 60, 1'b1);
      repeat (2) push_request(OP_TICK, 0, 0, 1'b1);
      gen_traffic(150);

      // Open limits, out-of-range maximum, crossed limits, zero tick, random, then calm.
      run_phase(0, 32767, 37, 350, 1'b0);
      run_phase(20000, 0, 255, 200, 1'b0);
      run_phase(32767, 5000, 0, 200, 1'b0);
      run_phase($urandom_range(0, 20000), $urandom_range(0, 20000), $urandom_range(1, 255),
                400, 1'b0);
      run_phase(100, 20000, 20, 500, 1'b1);
      wait_drain();

      if (mismatch_count == 0)
         $display("eased_decel_ramp_slew_limited_top: match");
      else
         $display("eased_decel_ramp_slew_limited_top: mismatch");
      $finish;
   end

endmodule
